[hw/rtl/cog_pkg.sv]
// Shared constants and types for the circle outline dot generator.
// Used by cog_isqrt and circle_outline_point_generator_top; depends on nothing.
`timescale 1ns / 1ps

package cog_pkg;

	localparam int COORD_W  = 12;
	localparam int RADIUS_W = 11;
	localparam int POS_W    = 14;
	localparam int SQ_W     = 2 * RADIUS_W;
	localparam int SIZE_W   = 8;
	localparam int COLOUR_W = 32;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 72;

	// Register indexes of the configuration port.
	localparam logic REG_DOT_SIZE   = 1'b0;
	localparam logic REG_DOT_COLOUR = 1'b1;

	// Item kinds on the input channel.
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_NEXT  = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RSQ  = 6'b000010,
		ST_DSQ  = 6'b000100,
		ST_CMP  = 6'b001000,
		ST_ROOT = 6'b010000,
		ST_PUT  = 6'b100000
	} seq_state_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_AXIS = 2'd1,
		PH_OCT  = 2'd2
	} phase_t;

	// Handshake between the sequencer and the root unit.
	typedef struct packed {
		logic            start;
		logic [SQ_W-1:0] operand;
	} sqrt_req_t;

	typedef struct packed {
		logic                done;
		logic [RADIUS_W-1:0] root;
	} sqrt_rsp_t;

endpackage

[hw/rtl/circle_outline_point_generator_top.sv]
// Top level of the circle outline dot generator: sequencer, shared multiplier,
// dot arithmetic and output register. Depends on cog_pkg and cog_isqrt.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid/s_tready    start or next item
// m_*       out        m_tvalid/m_tready    one dot (or empty result) per item
// cfg_*     in         cfg_valid/cfg_ready  register write, always ready
//
// Every input item gives exactly one result item. A next item inside a group
// is accepted, then loaded into the output register. A start item has its
// radius squared between accept and load.
// The next item that ends a group of dots, when the next offset needs a root,
// goes through accept, one multiply, one compare, eleven steps of the shared
// square root unit and the state that sees it finish, then the load. If the
// squared offset already exceeds the squared radius the root is skipped.
// The input is taken again as soon as the output register has been loaded,
// even while that result still waits for m_tready. Reset is asynchronous and
// leaves the block idle with no circle in progress.

module circle_outline_point_generator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [11:0] center_x, [23:12] center_y, [34:24] radius, [39:35] zero
	input  logic [cog_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] kind
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [13:0] pos_x, [27:14] pos_y, [35:28] dot_edge, [67:36] colour, [71:68] zero
	output logic [cog_pkg::OUT_DATA_W-1:0] m_tdata,
	// [0] valid_res
	output logic                           m_tuser,
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [cog_pkg::COLOUR_W-1:0]   cfg_data
);
	import cog_pkg::*;

	seq_state_t          st_q;
	phase_t              phase_q;
	logic [COORD_W-1:0]  cx_q;
	logic [COORD_W-1:0]  cy_q;
	logic [RADIUS_W-1:0] rad_q;
	logic [RADIUS_W-1:0] dx_q;
	logic [RADIUS_W-1:0] q_q;
	logic [2:0]          idx_q;
	logic [RADIUS_W-1:0] cand_q;
	logic [SQ_W-1:0]     r2_q;
	logic [SQ_W-1:0]     d2_q;

	logic [SIZE_W-1:0]   dot_size_q;
	logic [COLOUR_W-1:0] dot_colour_q;

	// Result waiting to be loaded into the output register.
	logic [POS_W-1:0]    res_x_q;
	logic [POS_W-1:0]    res_y_q;
	logic                res_valid_q;
	logic                res_last_q;

	// Output register.
	logic                out_valid_q;
	logic [POS_W-1:0]    out_x_q;
	logic [POS_W-1:0]    out_y_q;
	logic [SIZE_W-1:0]   out_edge_q;
	logic [COLOUR_W-1:0] out_colour_q;
	logic                out_res_q;
	logic                out_last_q;

	logic                in_acc;
	logic                out_free;
	logic                in_kind;
	logic [COORD_W-1:0]  in_cx;
	logic [COORD_W-1:0]  in_cy;
	logic [RADIUS_W-1:0] in_rad;

	logic [RADIUS_W-1:0] mul_op;
	logic [SQ_W-1:0]     mul_prod;

	logic [POS_W-1:0]    cx_w, cy_w, r_w, dx_w, q_w;
	logic [POS_W-1:0]    dot_x, dot_y;
	logic                grp_end;
	logic [RADIUS_W-1:0] next_dx;

	sqrt_req_t           sq_req;
	sqrt_rsp_t           sq_rsp;

	assign s_tready  = (st_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	assign in_kind = s_tuser;
	assign in_cx   = s_tdata[COORD_W-1:0];
	assign in_cy   = s_tdata[2*COORD_W-1:COORD_W];
	assign in_rad  = s_tdata[2*COORD_W+RADIUS_W-1:2*COORD_W];

	// The single multiplier squares the radius once per circle and each
	// candidate offset once per group.
	assign mul_op   = (st_q == ST_RSQ) ? rad_q : cand_q;
	assign mul_prod = SQ_W'(mul_op) * SQ_W'(mul_op);

	assign cx_w = POS_W'(cx_q);
	assign cy_w = POS_W'(cy_q);
	assign r_w  = POS_W'(rad_q);
	assign dx_w = POS_W'(dx_q);
	assign q_w  = POS_W'(q_q);

	// Position of the current dot. The minus side of the octant pairs sits one
	// pixel further out, which matches truncating the root of r*r - dx*dx + 0.5.
	always_comb begin
		dot_x = cx_w;
		dot_y = cy_w;
		if (phase_q == PH_AXIS) begin
			case (idx_q[1:0])
				2'd0: begin dot_x = cx_w;        dot_y = cy_w + r_w; end
				2'd1: begin dot_x = cx_w;        dot_y = cy_w - r_w; end
				2'd2: begin dot_x = cx_w + r_w;  dot_y = cy_w;       end
				default: begin dot_x = cx_w - r_w; dot_y = cy_w;     end
			endcase
		end else begin
			case (idx_q)
				3'd0: begin dot_x = cx_w + dx_w;       dot_y = cy_w + q_w;        end
				3'd1: begin dot_x = cx_w + dx_w;       dot_y = cy_w - q_w - 1'b1; end
				3'd2: begin dot_x = cx_w - dx_w;       dot_y = cy_w + q_w;        end
				3'd3: begin dot_x = cx_w - dx_w;       dot_y = cy_w - q_w - 1'b1; end
				3'd4: begin dot_x = cx_w + q_w;        dot_y = cy_w + dx_w;       end
				3'd5: begin dot_x = cx_w + q_w;        dot_y = cy_w - dx_w;       end
				3'd6: begin dot_x = cx_w - q_w - 1'b1; dot_y = cy_w + dx_w;       end
				default: begin dot_x = cx_w - q_w - 1'b1; dot_y = cy_w - dx_w;    end
			endcase
		end
	end

	// The last dot of a group triggers the search for the next group.
	assign grp_end = (phase_q == PH_AXIS) ? (idx_q == 3'd3) : (idx_q == 3'd7);
	assign next_dx = (phase_q == PH_AXIS) ? RADIUS_W'(1) : (dx_q + 1'b1);

	assign sq_req.start   = (st_q == ST_CMP) && (d2_q <= r2_q);
	assign sq_req.operand = r2_q - d2_q;

	cog_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_size_q   <= SIZE_W'(1);
			dot_colour_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DOT_SIZE:   dot_size_q   <= cfg_data[SIZE_W-1:0];
				REG_DOT_COLOUR: dot_colour_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and circle state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			phase_q     <= PH_IDLE;
			cx_q        <= '0;
			cy_q        <= '0;
			rad_q       <= '0;
			dx_q        <= '0;
			q_q         <= '0;
			idx_q       <= '0;
			cand_q      <= '0;
			r2_q        <= '0;
			d2_q        <= '0;
			res_x_q     <= '0;
			res_y_q     <= '0;
			res_valid_q <= 1'b0;
			res_last_q  <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						res_x_q     <= '0;
						res_y_q     <= '0;
						res_valid_q <= 1'b0;
						res_last_q  <= 1'b0;
						if (in_kind == KIND_START) begin
							cx_q    <= in_cx;
							cy_q    <= in_cy;
							rad_q   <= in_rad;
							dx_q    <= '0;
							q_q     <= '0;
							idx_q   <= '0;
							phase_q <= PH_AXIS;
							st_q    <= ST_RSQ;
						end else if (phase_q == PH_AXIS || phase_q == PH_OCT) begin
							res_x_q     <= dot_x;
							res_y_q     <= dot_y;
							res_valid_q <= 1'b1;
							if (!grp_end) begin
								idx_q <= idx_q + 1'b1;
								st_q  <= ST_PUT;
							end else if (next_dx == '0) begin
								// Offset wrapped around: no further group.
								phase_q    <= PH_IDLE;
								idx_q      <= '0;
								res_last_q <= 1'b1;
								st_q       <= ST_PUT;
							end else begin
								cand_q <= next_dx;
								st_q   <= ST_DSQ;
							end
						end else begin
							st_q <= ST_PUT;
						end
					end
				end
				ST_RSQ: begin
					r2_q <= mul_prod;
					st_q <= ST_PUT;
				end
				ST_DSQ: begin
					d2_q <= mul_prod;
					st_q <= ST_CMP;
				end
				ST_CMP: begin
					if (d2_q > r2_q) begin
						phase_q    <= PH_IDLE;
						idx_q      <= '0;
						res_last_q <= 1'b1;
						st_q       <= ST_PUT;
					end else begin
						st_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (sq_rsp.done) begin
						if (cand_q > sq_rsp.root) begin
							phase_q    <= PH_IDLE;
							idx_q      <= '0;
							res_last_q <= 1'b1;
						end else begin
							phase_q <= PH_OCT;
							dx_q    <= cand_q;
							q_q     <= sq_rsp.root;
							idx_q   <= '0;
						end
						st_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Output register; an empty result carries zeros in every field.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_x_q      <= '0;
			out_y_q      <= '0;
			out_edge_q   <= '0;
			out_colour_q <= '0;
			out_res_q    <= 1'b0;
			out_last_q   <= 1'b0;
		end else if (st_q == ST_PUT && out_free) begin
			out_valid_q  <= 1'b1;
			out_x_q      <= res_x_q;
			out_y_q      <= res_y_q;
			out_edge_q   <= res_valid_q ? dot_size_q : '0;
			out_colour_q <= res_valid_q ? dot_colour_q : '0;
			out_res_q    <= res_valid_q;
			out_last_q   <= res_last_q;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_colour_q, out_edge_q, out_y_q, out_x_q};
	assign m_tuser  = out_res_q;
	assign m_tlast  = out_last_q;

endmodule

[hw/rtl/cog_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
// Depends on cog_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module cog_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  cog_pkg::sqrt_req_t req,
	output cog_pkg::sqrt_rsp_t rsp
);
	import cog_pkg::*;

	logic [SQ_W-1:0] rem_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic            busy_q;
	logic [SQ_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			res_q  <= '0;
			bit_q  <= '0;
			busy_q <= 1'b0;
		end else if (req.start) begin
			rem_q  <= req.operand;
			res_q  <= '0;
			bit_q  <= SQ_W'(1) << (SQ_W - 2);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (bit_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end

	assign rsp.done = busy_q && (bit_q == '0);
	assign rsp.root = res_q[RADIUS_W-1:0];

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for circle_outline_point_generator_top: directed and random
// start/next items with random stalls, every dot predicted and compared in order.
// Depends on cog_pkg and the top level of the block.

module tb;
	import cog_pkg::*;

	// Long receiver hold-off, used once so the block fills up and stalls its input.
	localparam int HOLD_OFF_CYCLES = 300;
	// Quiet cycles after the last result before the verdict.
	localparam int SETTLE_CYCLES   = 30;
	localparam int RANDOM_ITEMS    = 1650;
	localparam int PHASES          = 8;

	// One result item as the block presents it, split into its fields.
	typedef struct packed {
		logic [13:0] pos_x;
		logic [13:0] pos_y;
		logic [7:0]  dot_edge;
		logic [31:0] colour;
		logic        valid_res;
		logic        last;
	} dot_t;

	// Tracks the circle in progress, computes the dot that each accepted item
	// produces and holds those dots until the block delivers them.
	class circle_dot_tracker;
		logic [7:0]  size_reg = 8'd1;
		logic [31:0] colour_reg = '0;
		logic [11:0] cx = '0;
		logic [11:0] cy = '0;
		logic [10:0] rad = '0;
		logic [10:0] dx = '0;
		logic [10:0] q = '0;
		logic [2:0]  idx = '0;
		phase_t      phase = PH_IDLE;
		dot_t        due_dots[$];
		int          mismatches = 0;

		function void set_reg(logic index, logic [31:0] value);
			if (index == REG_DOT_SIZE)
				size_reg = value[7:0];
			else
				colour_reg = value;
		endfunction

		function bit in_run();
			return phase != PH_IDLE;
		endfunction

		// Exact integer square root of a value below 2**22, built bit by bit.
		function int unsigned isqrt(int unsigned v);
			int unsigned root;
			int unsigned trial;
			root = 0;
			for (int b = 10; b >= 0; b--) begin
				trial = root | (32'd1 << b);
				if (trial * trial <= v)
					root = trial;
			end
			return root;
		endfunction

		// A group of eight dots at offset step exists while step <= isqrt(R*R - step*step).
		function bit group_for(logic [10:0] step, output logic [10:0] root_out);
			int unsigned r2;
			int unsigned d2;
			int unsigned root;
			root_out = '0;
			r2 = rad * rad;
			d2 = step * step;
			if (d2 > r2)
				return 0;
			root = isqrt(r2 - d2);
			if (step > root)
				return 0;
			root_out = root[10:0];
			return 1;
		endfunction

		function void take_request(logic kind, logic [11:0] cx_in, logic [11:0] cy_in,
				logic [10:0] r_in);
			dot_t        d;
			int          px;
			int          py;
			logic [10:0] nq;
			logic [10:0] ndx;
			bit          fin;
			bit          given;
			d = '0;
			px = 0;
			py = 0;
			fin = 1'b0;
			given = 1'b0;
			if (kind == KIND_START) begin
				// A start always answers with an empty result, even mid-run.
				cx = cx_in;
				cy = cy_in;
				rad = r_in;
				dx = '0;
				q = '0;
				idx = '0;
				phase = PH_AXIS;
			end else if (phase == PH_AXIS) begin
				given = 1'b1;
				case (idx[1:0])
					2'd0: begin px = cx; py = cy + rad; end
					2'd1: begin px = cx; py = cy - rad; end
					2'd2: begin px = cx + rad; py = cy; end
					default: begin px = cx - rad; py = cy; end
				endcase
				if (idx == 3'd3) begin
					idx = '0;
					if (group_for(11'd1, nq)) begin
						phase = PH_OCT;
						dx = 11'd1;
						q = nq;
					end else begin
						phase = PH_IDLE;
						fin = 1'b1;
					end
				end else begin
					idx++;
				end
			end else if (phase == PH_OCT) begin
				given = 1'b1;
				// The minus side sits one pixel further out than the plus side.
				case (idx)
					3'd0: begin px = cx + dx; py = cy + q; end
					3'd1: begin px = cx + dx; py = cy - q - 1; end
					3'd2: begin px = cx - dx; py = cy + q; end
					3'd3: begin px = cx - dx; py = cy - q - 1; end
					3'd4: begin px = cx + q; py = cy + dx; end
					3'd5: begin px = cx + q; py = cy - dx; end
					3'd6: begin px = cx - q - 1; py = cy + dx; end
					default: begin px = cx - q - 1; py = cy - dx; end
				endcase
				if (idx == 3'd7) begin
					idx = '0;
					ndx = dx + 11'd1;
					if (ndx != '0 && group_for(ndx, nq)) begin
						dx = ndx;
						q = nq;
					end else begin
						phase = PH_IDLE;
						fin = 1'b1;
					end
				end else begin
					idx++;
				end
			end
			// Only a next item inside a run gives a dot; all else is an empty result.
			if (given) begin
				d.pos_x = 14'(px);
				d.pos_y = 14'(py);
				d.dot_edge = size_reg;
				d.colour = colour_reg;
				d.valid_res = 1'b1;
				d.last = fin;
			end
			due_dots.push_back(d);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
					$time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_dot(logic [OUT_DATA_W-1:0] data, logic user, logic tlast);
			dot_t want;
			if (due_dots.size() == 0) begin
				$display("%0t: unexpected result, expected none, got data 0x%0h user %0b last %0b",
					$time, data, user, tlast);
				mismatches++;
				return;
			end
			want = due_dots.pop_front();
			compare_field("pos_x", want.pos_x, data[13:0]);
			compare_field("pos_y", want.pos_y, data[27:14]);
			compare_field("dot_edge", want.dot_edge, data[35:28]);
			compare_field("colour", want.colour, data[67:36]);
			compare_field("valid_res", want.valid_res, user);
			compare_field("last", want.last, tlast);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_index;
	logic [COLOUR_W-1:0]   cfg_data;

	circle_dot_tracker outline;

	// Knobs shared between the stimulus and the receiver process.
	bit hold_off_req   = 1'b0;
	bit sender_steady  = 1'b0;
	bit sink_steady    = 1'b0;
	bit pause_pending  = 1'b0;
	int items_sent     = 0;

	circle_outline_point_generator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every accepted result is checked against the oldest predicted dot.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
			outline.check_dot(m_tdata, m_tuser, m_tlast);
	end

	// Receiver: random runs of ready and stall, mostly short stalls with a few long
	// ones. On request it holds off for a long fixed stretch so the block backs up.
	initial begin
		int run_left;
		int pick;
		run_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				m_tready <= 1'b1;
				run_left = 4;
			end else if (sink_steady) begin
				m_tready <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
			end else if (m_tready) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					run_left = $urandom_range(0, 1);
				else if (pick < 95)
					run_left = $urandom_range(2, 9);
				else
					run_left = $urandom_range(19, 59);
				m_tready <= 1'b0;
			end else begin
				run_left = $urandom_range(0, 11);
				m_tready <= 1'b1;
			end
		end
	end

	// The run is cut off well beyond the slowest plausible correct run.
	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Sender gap after an item: mostly none, sometimes a few cycles, rarely long.
	function automatic int pick_gap();
		int pick;
		if (sender_steady)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 65)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Centers are pushed toward the edges often enough to make dots wrap below zero.
	function automatic logic [11:0] pick_coord();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			return 12'($urandom_range(0, 63));
		if (pick < 40)
			return 12'($urandom_range(4032, 4095));
		return 12'($urandom);
	endfunction

	// Offers one item and holds it until the block takes it. valid stays high when
	// no gap follows, so the next item goes out on the following edge.
	task automatic send_item(input logic kind, input logic [11:0] cx, input logic [11:0] cy,
			input logic [10:0] rad);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {5'b0, rad, cy, cx};
		do @(posedge clk); while (s_tready !== 1'b1);
		outline.take_request(kind, cx, cy, rad);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Next items carry random payload, which the block must ignore.
	task automatic send_next();
		send_item(KIND_NEXT, 12'($urandom), 12'($urandom), 11'($urandom));
	endtask

	task automatic wait_drained();
		while (outline.due_dots.size() != 0)
			@(posedge clk);
	endtask

	// One write, then cfg_valid is dropped before the task returns, so that writes never overlap in one time step.
	task automatic write_reg(input logic index, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		outline.set_reg(index, value);
		@(posedge clk);
	endtask

	// One well-formed circle with a random radius. Most circles run to their last dot;
	// some are cut short by the next start, and large ones always are. The circle also
	// stops once the item count of the current phase has been reached.
	task automatic run_random_circle(input int limit);
		int          pick;
		int          budget;
		int          n;
		logic [10:0] rad;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			rad = 11'($urandom_range(0, 3));
		else if (pick < 68)
			rad = 11'($urandom_range(4, 16));
		else if (pick < 88)
			rad = 11'($urandom_range(17, 60));
		else if (pick < 92)
			rad = 11'($urandom_range(61, 120));
		else
			rad = 11'($urandom_range(121, 2047));
		if (rad > 120 || $urandom_range(0, 3) == 0)
			budget = $urandom_range(1, 60);
		else
			budget = 1 << 30;
		send_item(KIND_START, pick_coord(), pick_coord(), rad);
		n = 0;
		while (outline.in_run() && n < budget && items_sent < limit) begin
			// Once in the run the sender waits mid-circle until every dot has come.
			if (pause_pending && n == 5) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				wait_drained();
				pause_pending = 1'b0;
			end
			send_next();
			n++;
		end
		// Sometimes one or two more next items follow; past the end of a circle they must come back empty.
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 2)) send_next();
	endtask

	initial begin
		int          phase_end;
		int          pick;
		logic [7:0]  size_val;
		logic [31:0] colour_val;
		outline = new();
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= KIND_START;
		cfg_valid <= 1'b0;
		cfg_index <= REG_DOT_SIZE;
		cfg_data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items with the reset register values. A next item before any start
		// must return an empty result.
		send_next();
		// Zero radius: four dots on the center, the fourth one last, then an empty one.
		send_item(KIND_START, 12'd0, 12'd0, 11'd0);
		repeat (5) send_next();
		// Largest radius at the corner: dots below zero and past the field edge,
		// abandoned by a new start during the run.
		send_item(KIND_START, 12'd0, 12'd4095, 11'd2047);
		repeat (5) send_next();
		// Radius one at the far corner: only the axis dots.
		send_item(KIND_START, 12'd4095, 12'd4095, 11'd1);
		repeat (4) send_next();
		// A start right behind a start simply replaces the circle.
		send_item(KIND_START, 12'd2048, 12'd2047, 11'd1024);
		send_item(KIND_START, 12'd4095, 12'd0, 11'd2);
		repeat (3) send_next();

		// Random part in phases; between phases the block is drained and both
		// registers are rewritten, starting with the extremes.
		for (int p = 0; p < PHASES; p++) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			wait_drained();
			case (p)
				0: begin size_val = 8'd255; colour_val = 32'hFFFF_FFFF; end
				1: begin size_val = 8'd1; colour_val = 32'h0000_0000; end
				default: begin
					size_val = 8'($urandom_range(1, 255));
					colour_val = $urandom;
				end
			endcase
			if ($urandom_range(0, 1) == 0) begin
				write_reg(REG_DOT_SIZE, {24'd0, size_val});
				write_reg(REG_DOT_COLOUR, colour_val);
			end else begin
				write_reg(REG_DOT_COLOUR, colour_val);
				write_reg(REG_DOT_SIZE, {24'd0, size_val});
			end
			sender_steady = (p % 3 == 1);
			sink_steady = (p % 3 == 2) && (p != 2);
			if (p == 2)
				hold_off_req = 1'b1;
			if (p == 4)
				pause_pending = 1'b1;
			phase_end = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					repeat ($urandom_range(1, 3)) send_next();
				end else if (pick < 12) begin
					send_item(KIND_START, 12'($urandom), 12'($urandom), 11'($urandom));
				end else begin
					run_random_circle(phase_end);
				end
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (outline.mismatches == 0 && outline.due_dots.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/cog_pkg.sv
hw/rtl/cog_isqrt.sv
hw/rtl/circle_outline_point_generator_top.sv
test/tb.sv
